// File: hw/rtl/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg: shared definitions for the piecewise-constant compressor
// Holds register indexes, multiplier operand codes, and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pcc_pkg;

	// Width of the error bound register and of the configuration port.
	localparam int EB_BITS        = 16;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 1;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] REG_ERROR_BOUND = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_USE_MEAN    = 1'b1;

	// Operand selection for the shared multiplier.
	typedef logic [1:0] pcc_mul_op_t;
	localparam pcc_mul_op_t MUL_MAX = 2'd0;
	localparam pcc_mul_op_t MUL_MIN = 2'd1;
	localparam pcc_mul_op_t MUL_EB  = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic        ld_in;
		logic        start;
		logic        extend;
		logic        clear;
		logic        mul_en;
		pcc_mul_op_t mul_op;
		logic        up_ld;
		logic        dn_ld;
		logic        div_init;
		logic        div_step;
		logic        out_ld;
		logic        out_fin;
	} pcc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic seg_open;
		logic len_full;
		logic use_mean;
		logic fits_mid;
		logic fits_mean;
		logic eos;
		logic div_done;
		logic out_free;
	} pcc_status_t;

endpackage

// File: hw/rtl/pcc_datapath.sv
// ----------------------------------------------------------------------------
// pcc_datapath: segment state, fit tests, divider and output register
// Keeps the open segment's extremes, sum and length, runs the midrange test
// directly and the mean test through one shared multiplier, forms the mean
// with a one-bit-per-cycle divider and holds the result beat until taken.
// ----------------------------------------------------------------------------
module pcc_datapath import pcc_pkg::*; #(
	parameter int SAMPLE_BITS = 16,
	parameter int LEN_BITS    = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [CFG_DATA_BITS-1:0]      cfg_data,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          end_of_stream,
	input  pcc_cmd_t                      cmd,
	output pcc_status_t                   status,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [LEN_BITS-1:0]           seg_length,
	output logic signed [SAMPLE_BITS-1:0] seg_value,
	output logic                          final_segment
);

	localparam int SUM_BITS = SAMPLE_BITS + LEN_BITS;
	localparam int AW       = (SAMPLE_BITS > EB_BITS) ? SAMPLE_BITS : EB_BITS + 1;
	localparam int BW       = LEN_BITS + 2;
	localparam int PW       = AW + BW;
	localparam int W        = PW + 1;
	localparam int CW       = SAMPLE_BITS + EB_BITS + 2;
	localparam int CNT_BITS = $clog2(SUM_BITS + 1);

	// Configuration registers.
	logic [EB_BITS-1:0] eb_q;
	logic               use_mean_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eb_q       <= '0;
			use_mean_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ERROR_BOUND: eb_q       <= cfg_data[EB_BITS-1:0];
				REG_USE_MEAN:    use_mean_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input beat latch.
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic                          eos_q;

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			x_q   <= sample;
			eos_q <= end_of_stream;
		end
	end

	// Open segment state.
	logic                          seg_open_q;
	logic [LEN_BITS-1:0]           run_len_q;
	logic signed [SAMPLE_BITS-1:0] min_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic signed [SAMPLE_BITS-1:0] mid_q;
	logic signed [SUM_BITS-1:0]    sum_q;

	// Extremes, sum and midrange with the new sample included.
	logic signed [SAMPLE_BITS-1:0] nmin;
	logic signed [SAMPLE_BITS-1:0] nmax;
	logic signed [SUM_BITS-1:0]    s_new;
	logic signed [SAMPLE_BITS:0]   msum;
	logic signed [SAMPLE_BITS:0]   madj;
	logic [LEN_BITS:0]             n;

	assign nmin  = (x_q < min_q) ? x_q : min_q;
	assign nmax  = (x_q > max_q) ? x_q : max_q;
	assign s_new = sum_q + SUM_BITS'(x_q);
	assign msum  = (SAMPLE_BITS + 1)'(nmax) + (SAMPLE_BITS + 1)'(nmin);
	// Add one to a negative sum so that the halving truncates toward zero.
	assign madj  = msum + $signed({{SAMPLE_BITS{1'b0}}, msum[SAMPLE_BITS]});
	assign n     = {1'b0, run_len_q} + (LEN_BITS + 1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_open_q <= 1'b0;
			run_len_q  <= '0;
		end else if (cmd.start) begin
			seg_open_q <= 1'b1;
			run_len_q  <= LEN_BITS'(1);
		end else if (cmd.extend) begin
			run_len_q  <= run_len_q + LEN_BITS'(1);
		end else if (cmd.clear) begin
			seg_open_q <= 1'b0;
			run_len_q  <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			min_q <= x_q;
			max_q <= x_q;
			mid_q <= x_q;
			sum_q <= SUM_BITS'(x_q);
		end else if (cmd.extend) begin
			min_q <= nmin;
			max_q <= nmax;
			mid_q <= madj[SAMPLE_BITS:1];
			sum_q <= s_new;
		end
	end

	// Midrange test: max - min against twice the bound.
	logic signed [SAMPLE_BITS:0] spread;
	logic [CW-1:0]               spread_w;
	logic [CW-1:0]               bound_w;

	assign spread   = (SAMPLE_BITS + 1)'(nmax) - (SAMPLE_BITS + 1)'(nmin);
	assign spread_w = CW'($unsigned(spread));
	assign bound_w  = CW'({eb_q, 1'b0});

	// Shared multiplier; the product is registered before any use.
	logic signed [AW-1:0] op_a;
	logic signed [BW-1:0] op_b;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] mul_q;

	always_comb begin
		case (cmd.mul_op)
			MUL_MAX: op_a = AW'(nmax);
			MUL_MIN: op_a = AW'(nmin);
			MUL_EB:  op_a = AW'({1'b0, eb_q});
			default: op_a = '0;
		endcase
	end

	assign op_b = $signed({1'b0, n});
	assign prod = op_a * op_b;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			mul_q <= prod;
		end
	end

	// Mean test: n*max - sum and sum - n*min against n*bound.
	logic signed [W-1:0] s_w;
	logic signed [W-1:0] prod_w;
	logic signed [W-1:0] up_q;
	logic signed [W-1:0] dn_q;

	assign s_w    = W'(s_new);
	assign prod_w = W'(mul_q);

	always_ff @(posedge clk) begin
		if (cmd.up_ld) begin
			up_q <= prod_w - s_w;
		end
		if (cmd.dn_ld) begin
			dn_q <= s_w - prod_w;
		end
	end

	// Restoring divider for sum / length on magnitudes, sign fixed at the end.
	logic [SUM_BITS-1:0] sum_mag;
	logic [LEN_BITS-1:0] rem_q;
	logic [SUM_BITS-1:0] quo_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                neg_q;
	logic [LEN_BITS:0]   trial;
	logic [LEN_BITS:0]   len_w;
	logic [LEN_BITS:0]   trial_sub;
	logic [SUM_BITS-1:0] quo_fix;

	assign sum_mag   = sum_q[SUM_BITS-1] ? (~sum_q + SUM_BITS'(1)) : sum_q;
	assign trial     = {rem_q, quo_q[SUM_BITS-1]};
	assign len_w     = {1'b0, run_len_q};
	assign trial_sub = trial - len_w;
	assign quo_fix   = neg_q ? (~quo_q + SUM_BITS'(1)) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_init) begin
			cnt_q <= CNT_BITS'(SUM_BITS);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= '0;
			quo_q <= sum_mag;
			neg_q <= sum_q[SUM_BITS-1];
		end else if (cmd.div_step) begin
			if (trial >= len_w) begin
				rem_q <= trial_sub[LEN_BITS-1:0];
				quo_q <= {quo_q[SUM_BITS-2:0], 1'b1};
			end else begin
				rem_q <= trial[LEN_BITS-1:0];
				quo_q <= {quo_q[SUM_BITS-2:0], 1'b0};
			end
		end
	end

	// Output register: holds one result beat until the sink takes it.
	logic                          out_valid_q;
	logic [LEN_BITS-1:0]           seg_length_q;
	logic signed [SAMPLE_BITS-1:0] seg_value_q;
	logic                          final_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			seg_length_q <= run_len_q;
			seg_value_q  <= use_mean_q ? $signed(quo_fix[SAMPLE_BITS-1:0]) : mid_q;
			final_q      <= cmd.out_fin;
		end
	end

	assign out_valid     = out_valid_q;
	assign seg_length    = seg_length_q;
	assign seg_value     = seg_value_q;
	assign final_segment = final_q;

	// Status back to the controller.
	assign status.seg_open  = seg_open_q;
	assign status.len_full  = &run_len_q;
	assign status.use_mean  = use_mean_q;
	assign status.fits_mid  = (spread_w <= bound_w);
	assign status.fits_mean = (up_q <= prod_w) && (dn_q <= prod_w);
	assign status.eos       = eos_q;
	assign status.div_done  = (cnt_q == '0);
	assign status.out_free  = !out_valid_q || out_ready;

endmodule

// File: hw/rtl/pcc_ctrl.sv
// ----------------------------------------------------------------------------
// pcc_ctrl: sequencing state machine of the compressor
// Takes one input beat at a time, steps the datapath through the fit test,
// and sequences the close, flush and restart of segments.
// ----------------------------------------------------------------------------
module pcc_ctrl import pcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  pcc_status_t status,
	output pcc_cmd_t    cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_EVAL  = 4'd1;
	localparam logic [3:0] S_MUL1  = 4'd2;
	localparam logic [3:0] S_MUL2  = 4'd3;
	localparam logic [3:0] S_MUL3  = 4'd4;
	localparam logic [3:0] S_CMP   = 4'd5;
	localparam logic [3:0] S_POST  = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;
	localparam logic [3:0] S_START = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       fin_q;
	logic       set_fin;
	logic       clr_fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (set_fin) begin
				fin_q <= 1'b1;
			end else if (clr_fin) begin
				fin_q <= 1'b0;
			end
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		set_fin  = 1'b0;
		clr_fin  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					state_d   = S_EVAL;
				end
			end
			S_EVAL: begin
				if (!status.seg_open) begin
					state_d = S_START;
				end else if (status.len_full || (!status.use_mean && !status.fits_mid)) begin
					// Close the open segment before the new sample starts another.
					clr_fin = 1'b1;
					if (status.use_mean) begin
						cmd.div_init = 1'b1;
						state_d      = S_DIV;
					end else begin
						state_d = S_OUT;
					end
				end else if (!status.use_mean) begin
					cmd.extend = 1'b1;
					state_d    = S_POST;
				end else begin
					state_d = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_MAX;
				state_d    = S_MUL2;
			end
			S_MUL2: begin
				cmd.up_ld  = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_MIN;
				state_d    = S_MUL3;
			end
			S_MUL3: begin
				cmd.dn_ld  = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_EB;
				state_d    = S_CMP;
			end
			S_CMP: begin
				if (status.fits_mean) begin
					cmd.extend = 1'b1;
					state_d    = S_POST;
				end else begin
					clr_fin      = 1'b1;
					cmd.div_init = 1'b1;
					state_d      = S_DIV;
				end
			end
			S_POST: begin
				// Flush the open segment when the stream ends here.
				if (status.eos) begin
					set_fin = 1'b1;
					if (status.use_mean) begin
						cmd.div_init = 1'b1;
						state_d      = S_DIV;
					end else begin
						state_d = S_OUT;
					end
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DIV: begin
				if (status.div_done) begin
					state_d = S_OUT;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_OUT: begin
				if (status.out_free) begin
					cmd.out_ld  = 1'b1;
					cmd.out_fin = fin_q;
					if (fin_q) begin
						cmd.clear = 1'b1;
						state_d   = S_IDLE;
					end else begin
						state_d = S_START;
					end
				end
			end
			S_START: begin
				cmd.start = 1'b1;
				state_d   = S_POST;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: hw/rtl/piecewise_constant_compressor.sv
// ----------------------------------------------------------------------------
// piecewise_constant_compressor: top level of the segment compressor
// Joins the controller and the datapath and exposes the stream channels
// and the configuration write port.
// ----------------------------------------------------------------------------
// Groups consecutive signed samples into constant segments and emits each
// closed segment as (seg_length, seg_value, final_segment). The block works
// on one sample at a time. In mean mode the exact mean test runs three
// products through one shared multiplier, and each emitted segment waits
// for the one-bit-per-cycle divider that forms sum / length. In either mode
// a sample that closes a segment passes through a start state that opens
// the new one. A result beat waits in an output register, so the next
// sample can be taken while the sink stalls; a further result waits until
// that register is free. Configuration must be written only while the
// block is idle; the block itself does not enforce this.
module piecewise_constant_compressor import pcc_pkg::*; #(
	parameter int SAMPLE_BITS = 16,
	parameter int LEN_BITS    = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [CFG_DATA_BITS-1:0]      cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          end_of_stream,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [LEN_BITS-1:0]           seg_length,
	output logic signed [SAMPLE_BITS-1:0] seg_value,
	output logic                          final_segment
);

	pcc_cmd_t    cmd;
	pcc_status_t status;

	pcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	pcc_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.LEN_BITS    (LEN_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.sample        (sample),
		.end_of_stream (end_of_stream),
		.cmd           (cmd),
		.status        (status),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.seg_length    (seg_length),
		.seg_value     (seg_value),
		.final_segment (final_segment)
	);

endmodule

// File: hw/rtl/pcc_checker.sv
// ----------------------------------------------------------------------------
// pcc_checker: port-level checks for the compressor
// Watches the top level's stream ports and flags behavior that the
// compressor must never show.
// ----------------------------------------------------------------------------
module pcc_checker #(
	parameter int SAMPLE_BITS = 16,
	parameter int LEN_BITS    = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic signed [SAMPLE_BITS-1:0] sample,
	input logic                          end_of_stream,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [LEN_BITS-1:0]           seg_length,
	input logic signed [SAMPLE_BITS-1:0] seg_value,
	input logic                          final_segment
);

	// A waiting input beat keeps its payload until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(sample) &&
		$stable(end_of_stream))
	else $error("input beat changed while waiting");

	// A stalled result beat stays put until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(seg_length) &&
		$stable(seg_value) && $stable(final_segment))
	else $error("result beat changed while stalled");

	// Every segment covers at least one sample.
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> seg_length != '0)
	else $error("segment of zero length");

	// A sample is processed before the next one is taken.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
	else $error("input taken in back-to-back cycles");

endmodule

bind piecewise_constant_compressor pcc_checker #(
	.SAMPLE_BITS (SAMPLE_BITS),
	.LEN_BITS    (LEN_BITS)
) u_pcc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.sample        (sample),
	.end_of_stream (end_of_stream),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.seg_length    (seg_length),
	.seg_value     (seg_value),
	.final_segment (final_segment)
);

// File: bench/tb_piecewise_constant_compressor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_piecewise_constant_compressor: self-checking bench for the compressor
// Streams signed samples with random gaps on the input and output channels.
// A behavioral model of the grouping rules predicts every segment beat, and
// each beat that leaves the block is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_piecewise_constant_compressor;
	import pcc_pkg::*;

	localparam int     SAMPLE_W      = 16;
	localparam int     LENGTH_W      = 16;
	localparam longint MAX_SEG_LEN   = 65535;
	localparam longint SAMPLE_HI     = 32767;
	localparam longint SAMPLE_LO     = -32768;
	localparam int     SETTLE_CYCLES = 150;
	localparam longint CYCLE_LIMIT   = 2_000_000;
	localparam int     REPORT_LIMIT  = 10;
	localparam int     RANDOM_PHASES = 8;
	localparam int     PHASE_ITEMS   = 88;
	localparam bit     MODE_MIDRANGE = 1'b0;
	localparam bit     MODE_MEAN     = 1'b1;

	typedef struct {
		logic [LENGTH_W-1:0]        length;
		logic signed [SAMPLE_W-1:0] value;
		logic                       fin;
	} segment_t;

	// Clock, reset and block ports.
	logic                       clk           = 1'b0;
	logic                       arst_n        = 1'b0;
	logic                       cfg_write     = 1'b0;
	logic [CFG_INDEX_BITS-1:0]  cfg_index     = '0;
	logic [CFG_DATA_BITS-1:0]   cfg_data      = '0;
	logic                       in_valid      = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample        = '0;
	logic                       end_of_stream = 1'b0;
	logic                       out_valid;
	logic                       out_ready     = 1'b0;
	logic [LENGTH_W-1:0]        seg_length;
	logic signed [SAMPLE_W-1:0] seg_value;
	logic                       final_segment;

	// Model of the open segment and of the registers.
	longint   seg_lo       = 0;
	longint   seg_hi       = 0;
	longint   seg_sum      = 0;
	longint   seg_len      = 0;
	longint   seg_mid      = 0;
	bit       seg_active   = 1'b0;
	longint   bound_reg    = 0;
	bit       mean_mode    = MODE_MIDRANGE;
	segment_t pending_segments[$];

	int     mismatches  = 0;
	bit     gaps_on     = 1'b1;
	int     sink_hold   = 0;
	longint cycle_count = 0;

	piecewise_constant_compressor dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample        (sample),
		.end_of_stream (end_of_stream),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.seg_length    (seg_length),
		.seg_value     (seg_value),
		.final_segment (final_segment)
	);

	// 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Gap length: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// True if sample x can join the open segment under the current mode.
	// The mean test is exact: both deviations are scaled by the new length.
	function automatic bit joins_segment(longint x);
		longint lo;
		longint hi;
		longint n;
		longint s;
		longint lim;
		lo = (x < seg_lo) ? x : seg_lo;
		hi = (x > seg_hi) ? x : seg_hi;
		if (mean_mode == MODE_MIDRANGE)
			return (hi - lo) <= 2 * bound_reg;
		n   = seg_len + 1;
		s   = seg_sum + x;
		lim = bound_reg * n;
		return (hi * n - s) <= lim && (s - lo * n) <= lim;
	endfunction

	// Queue the open segment as one expected beat. The mode in force at
	// closing time picks the value; both divisions truncate toward zero.
	task automatic close_segment(input bit fin);
		segment_t seg;
		longint   v;
		v = (mean_mode == MODE_MEAN && seg_len != 0) ? seg_sum / seg_len : seg_mid;
		seg.length = seg_len[LENGTH_W-1:0];
		seg.value  = v[SAMPLE_W-1:0];
		seg.fin    = fin;
		pending_segments.push_back(seg);
	endtask

	task automatic open_segment(input longint x);
		seg_lo     = x;
		seg_hi     = x;
		seg_sum    = x;
		seg_len    = 1;
		seg_mid    = x;
		seg_active = 1'b1;
	endtask

	// Advance the model by one accepted sample and queue the segments it closes.
	task automatic predict_segments(input logic signed [SAMPLE_W-1:0] s, input logic eos);
		longint x;
		x = s;
		if (!seg_active) begin
			open_segment(x);
		end else if (seg_len >= MAX_SEG_LEN || !joins_segment(x)) begin
			close_segment(1'b0);
			open_segment(x);
		end else begin
			if (x < seg_lo)
				seg_lo = x;
			if (x > seg_hi)
				seg_hi = x;
			seg_sum += x;
			seg_len++;
			seg_mid = (seg_hi + seg_lo) / 2;
		end
		if (eos) begin
			close_segment(1'b1);
			seg_active = 1'b0;
			seg_lo     = 0;
			seg_hi     = 0;
			seg_sum    = 0;
			seg_len    = 0;
			seg_mid    = 0;
		end
	endtask

	// Send one sample beat. Valid stays high after acceptance so that a
	// following beat with no gap goes out back to back.
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic eos);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		sample        <= s;
		end_of_stream <= eos;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_segments(s, eos);
	endtask

	// Hold the sender until every expected segment has arrived, then let the
	// block finish any work that produces no beat.
	task automatic wait_until_drained();
		in_valid <= 1'b0;
		while (pending_segments.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		if (idx == REG_ERROR_BOUND)
			bound_reg = data;
		else if (idx == REG_USE_MEAN)
			mean_mode = data[0];
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// Reconfigure while idle. The mode write carries random upper bits,
	// which the block must ignore.
	task automatic configure(input logic [CFG_DATA_BITS-1:0] bound, input bit mode);
		logic [CFG_DATA_BITS-1:0] mode_word;
		wait_until_drained();
		mode_word    = CFG_DATA_BITS'($urandom);
		mode_word[0] = mode;
		write_register(REG_ERROR_BOUND, bound);
		write_register(REG_USE_MEAN, mode_word);
	endtask

	// Reset values: bound zero in midrange mode, so any change breaks a segment.
	task automatic test_reset_defaults();
		send_sample(16'sd5, 1'b0);
		send_sample(16'sd5, 1'b0);
		send_sample(16'sd6, 1'b0);
		send_sample(16'sd6, 1'b1);
		// A flush with no segment open yields a one-sample final segment.
		send_sample(-16'sd7, 1'b1);
	endtask

	// Full-scale samples and bounds in both modes, and a break that
	// coincides with a flush.
	task automatic test_field_extremes();
		configure(16'hFFFF, MODE_MIDRANGE);
		send_sample(-16'sd32768, 1'b0);
		send_sample(16'sd32767, 1'b1);
		configure(16'h0000, MODE_MEAN);
		send_sample(16'sd32767, 1'b0);
		send_sample(16'sd32767, 1'b0);
		send_sample(-16'sd32768, 1'b1);
		configure(16'hFFFF, MODE_MEAN);
		send_sample(-16'sd32768, 1'b0);
		send_sample(16'sd32767, 1'b0);
		send_sample(-16'sd32768, 1'b0);
		send_sample(16'sd0, 1'b1);
	endtask

	// Negative midrange and mean values truncate toward zero; a mean-mode
	// break on a large upward step.
	task automatic test_truncation();
		configure(16'd2, MODE_MIDRANGE);
		send_sample(-16'sd3, 1'b0);
		send_sample(-16'sd6, 1'b1);
		configure(16'd1, MODE_MEAN);
		send_sample(-16'sd3, 1'b0);
		send_sample(-16'sd4, 1'b1);
		send_sample(16'sd0, 1'b0);
		send_sample(16'sd0, 1'b0);
		send_sample(16'sd3, 1'b1);
	endtask

	// The mode is switched while a segment is open: the mode in force when
	// the segment closes decides both the break test and the value.
	task automatic test_mode_switch();
		configure(16'd10, MODE_MIDRANGE);
		send_sample(16'sd0, 1'b0);
		send_sample(16'sd4, 1'b0);
		send_sample(16'sd20, 1'b0);
		configure(16'd10, MODE_MEAN);
		send_sample(16'sd5, 1'b1);
		configure(16'd4, MODE_MEAN);
		send_sample(16'sd0, 1'b0);
		send_sample(16'sd0, 1'b0);
		send_sample(16'sd6, 1'b0);
		configure(16'd4, MODE_MIDRANGE);
		send_sample(16'sd20, 1'b1);
	endtask

	// A segment that reaches the length limit is closed before the next
	// sample; here that sample also flushes, so one sample yields two beats.
	task automatic test_length_limit();
		logic signed [SAMPLE_W-1:0] s;
		gaps_on = 1'b0;
		configure(16'hFFFF, MODE_MIDRANGE);
		for (longint i = 0; i < MAX_SEG_LEN; i++) begin
			s = SAMPLE_W'($urandom);
			send_sample(s, 1'b0);
		end
		s = SAMPLE_W'($urandom);
		send_sample(s, 1'b1);
		gaps_on = 1'b1;
	endtask

	// Random phases. Samples mostly wander around a level within a spread
	// tied to the bound, so segments grow and break naturally; some jump to
	// a new level and a few are full-range noise.
	task automatic test_random_streams();
		logic [CFG_DATA_BITS-1:0]   bound;
		logic signed [SAMPLE_W-1:0] s;
		longint level;
		longint spread;
		longint x;
		int     r;
		level = 0;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0)
				bound = 16'h0000;
			else if (p == 1)
				bound = 16'hFFFF;
			else begin
				r = $urandom_range(0, 9);
				if (r < 5)
					bound = CFG_DATA_BITS'($urandom_range(1, 16));
				else if (r < 8)
					bound = CFG_DATA_BITS'($urandom_range(17, 2000));
				else
					bound = CFG_DATA_BITS'($urandom);
			end
			configure(bound, p[0] ? MODE_MEAN : MODE_MIDRANGE);
			gaps_on = (p != 5);
			spread  = ((bound > 4000) ? 4000 : bound) + $urandom_range(0, 1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				r = $urandom_range(0, 99);
				if (r < 6) begin
					s     = SAMPLE_W'($urandom);
					level = s;
				end
				if (r < 4) begin
					s = SAMPLE_W'($urandom);
				end else begin
					x = level + longint'($urandom_range(0, 32'(2 * spread))) - spread;
					if (x > SAMPLE_HI)
						x = SAMPLE_HI;
					if (x < SAMPLE_LO)
						x = SAMPLE_LO;
					s = x[SAMPLE_W-1:0];
				end
				send_sample(s, $urandom_range(0, 29) == 0);
			end
		end
		gaps_on = 1'b1;
		s = SAMPLE_W'($urandom);
		send_sample(s, 1'b1);
	endtask

	// Output side: random stalls, none while gaps are switched off.
	always @(posedge clk) begin
		if (!gaps_on) begin
			out_ready <= 1'b1;
		end else if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
		end else if (out_ready) begin
			out_ready <= 1'b0;
			sink_hold <= pick_gap();
		end else begin
			out_ready <= 1'b1;
			sink_hold <= $urandom_range(0, 15);
		end
	end

	// Compare each accepted segment beat with the oldest expectation.
	always @(posedge clk) begin : check_segments
		segment_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_segments.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected segment: length %0d value %0d final %0d",
						seg_length, seg_value, final_segment);
			end else begin
				want = pending_segments.pop_front();
				if (seg_length !== want.length || seg_value !== want.value ||
					final_segment !== want.fin) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("segment mismatch: expected length %0d value %0d final %0d, got length %0d value %0d final %0d",
							want.length, want.value, want.fin,
							seg_length, seg_value, final_segment);
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("piecewise_constant_compressor test failed");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_field_extremes();
		test_truncation();
		test_mode_switch();
		test_length_limit();
		test_random_streams();
		wait_until_drained();
		if (mismatches == 0 && pending_segments.size() == 0)
			$display("piecewise_constant_compressor test passed");
		else
			$display("piecewise_constant_compressor test failed");
		$finish;
	end

endmodule

// File: piecewise_constant_compressor.f
hw/rtl/pcc_pkg.sv
hw/rtl/pcc_datapath.sv
hw/rtl/pcc_ctrl.sv
hw/rtl/piecewise_constant_compressor.sv
hw/rtl/pcc_checker.sv
bench/tb_piecewise_constant_compressor.sv
